// ===== sv/sfs_pkg.sv =====
// Shared types and constants for the SPI NOR flash sequencer.
// Holds the host command codes, flash opcodes, phase encoding and result record.
// No dependencies.
`default_nettype none

package sfs_pkg;

    localparam int ADDR_W    = 24;
    localparam int MAX_RES   = 8;
    localparam int RES_IDX_W = $clog2(MAX_RES);
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);

    // Host command codes; the operation register uses the same codes.
    localparam logic [3:0] CMD_REPLY  = 4'd0;
    localparam logic [3:0] CMD_READ   = 4'd1;
    localparam logic [3:0] CMD_PROG   = 4'd2;
    localparam logic [3:0] CMD_SERASE = 4'd3;
    localparam logic [3:0] CMD_CERASE = 4'd4;
    localparam logic [3:0] CMD_EPROG  = 4'd5;
    localparam logic [3:0] CMD_STATUS = 4'd6;
    localparam logic [3:0] CMD_ID     = 4'd7;
    localparam logic [3:0] CMD_WAKE   = 4'd8;
    localparam logic [3:0] CMD_DATA   = 4'd9;
    localparam logic [3:0] OP_NONE    = 4'd0;

    // Flash opcodes and the status register's busy bit.
    localparam logic [7:0] FL_WREN  = 8'h06;
    localparam logic [7:0] FL_WRDI  = 8'h04;
    localparam logic [7:0] FL_RDSR  = 8'h05;
    localparam logic [7:0] FL_READ  = 8'h03;
    localparam logic [7:0] FL_PP    = 8'h02;
    localparam logic [7:0] FL_SE    = 8'h20;
    localparam logic [7:0] FL_CE    = 8'hC7;
    localparam logic [7:0] FL_RDID  = 8'h9F;
    localparam logic [7:0] FL_RES   = 8'hAB;
    localparam logic [7:0] FL_DUMMY = 8'hFF;
    localparam logic [7:0] SR_BUSY  = 8'h01;

    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_READ = 6'b000010,
        PH_PROG = 6'b000100,
        PH_POLL = 6'b001000,
        PH_STAT = 6'b010000,
        PH_ID   = 6'b100000
    } phase_t;

    typedef struct packed {
        logic       mosi_valid;
        logic [7:0] mosi_byte;
        logic       frame_end;
        logic       want_reply;
        logic       host_valid;
        logic [7:0] host_byte;
        logic       op_done;
        logic       rejected;
        logic       last;
    } res_t;

    function automatic res_t tx_res(logic [7:0] b, logic fe, logic wr);
        res_t r;
        r            = '0;
        r.mosi_valid = 1'b1;
        r.mosi_byte  = b;
        r.frame_end  = fe;
        r.want_reply = wr;
        return r;
    endfunction

    function automatic res_t host_res(logic [7:0] b);
        res_t r;
        r            = '0;
        r.host_valid = 1'b1;
        r.host_byte  = b;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/sfs_core.sv =====
// Sequencer state and the single-pass step logic of the SPI NOR flash sequencer.
// Turns one request into its list of result records; uses sfs_pkg.
`default_nettype none

module sfs_core
    import sfs_pkg::*;
#(
    parameter int PAGE_BYTES   = 256,
    parameter int SECTOR_BYTES = 4096
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    fire,
    input  wire logic [3:0]              command,
    input  wire logic [ADDR_W-1:0]       address,
    input  wire logic [ADDR_W-1:0]       length,
    input  wire logic [7:0]              data_byte,
    output res_t      [MAX_RES-1:0]      list,
    output logic      [RES_CNT_W-1:0]    count
);

    // Page and sector sizes are powers of two, so offsets are masks.
    localparam int PG_W  = $clog2(PAGE_BYTES);
    localparam int PBL_W = PG_W + 1;
    localparam logic [ADDR_W-1:0] SEC_MASK = ~(ADDR_W'(SECTOR_BYTES - 1));

    phase_t             phase_reg, phase_next;
    logic [3:0]         op_reg, op_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [ADDR_W-1:0]  rem_reg, rem_next;
    logic [ADDR_W:0]    end_reg, end_next;
    logic [PBL_W-1:0]   pbl_reg, pbl_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            op_reg    <= OP_NONE;
            addr_reg  <= '0;
            rem_reg   <= '0;
            end_reg   <= '0;
            pbl_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            op_reg    <= op_next;
            addr_reg  <= addr_next;
            rem_reg   <= rem_next;
            end_reg   <= end_next;
            pbl_reg   <= pbl_next;
        end
    end

    always_comb
    begin
        logic [RES_CNT_W-1:0] n;
        logic [RES_CNT_W-1:0] nl;
        logic                 finished;
        logic                 reject;
        logic                 do_sector;
        logic                 do_page;
        logic                 do_poll;
        logic [ADDR_W-1:0]    sec_addr;
        logic [ADDR_W-1:0]    rem_dec;
        logic [ADDR_W:0]      nxt;
        logic [ADDR_W:0]      diff;
        logic [PG_W-1:0]      off;
        logic [PBL_W-1:0]     room;

        phase_next = phase_reg;
        op_next    = op_reg;
        addr_next  = addr_reg;
        rem_next   = rem_reg;
        end_next   = end_reg;
        pbl_next   = pbl_reg;
        list       = '0;
        n          = '0;
        finished   = 1'b0;
        reject     = 1'b0;
        do_sector  = 1'b0;
        do_page    = 1'b0;
        do_poll    = 1'b0;
        sec_addr   = address;
        rem_dec    = (rem_reg != '0) ? rem_reg - ADDR_W'(1) : rem_reg;
        nxt        = {1'b0, addr_reg} + (ADDR_W + 1)'(SECTOR_BYTES);
        diff       = end_reg - {1'b0, rem_reg};
        off        = '0;
        room       = '0;

        unique case (phase_reg)
            PH_IDLE:
            begin
                case (command)
                    CMD_READ:
                    begin
                        list[n[RES_IDX_W-1:0]] = tx_res(FL_READ, 1'b0, 1'b0);
                        n = n + 1'b1;
                        list[n[RES_IDX_W-1:0]] = tx_res(address[23:16], 1'b0, 1'b0);
                        n = n + 1'b1;
                        list[n[RES_IDX_W-1:0]] = tx_res(address[15:8], 1'b0, 1'b0);
                        n = n + 1'b1;
                        if (length == '0)
                        begin
                            list[n[RES_IDX_W-1:0]] = tx_res(address[7:0], 1'b1, 1'b0);
                            n = n + 1'b1;
                            finished = 1'b1;
                        end
                        else
                        begin
                            list[n[RES_IDX_W-1:0]] = tx_res(address[7:0], 1'b0, 1'b0);
                            n = n + 1'b1;
                            list[n[RES_IDX_W-1:0]] = tx_res(FL_DUMMY,
                                                            length == ADDR_W'(1), 1'b1);
                            n = n + 1'b1;
                            rem_next   = length;
                            op_next    = CMD_READ;
                            phase_next = PH_READ;
                        end
                    end
                    CMD_PROG:
                    begin
                        if (length == '0)
                        begin
                            n = n + 1'b1;
                            finished = 1'b1;
                        end
                        else
                        begin
                            addr_next = address;
                            rem_next  = length;
                            op_next   = CMD_PROG;
                            do_page   = 1'b1;
                        end
                    end
                    CMD_SERASE:
                    begin
                        op_next   = CMD_SERASE;
                        do_sector = 1'b1;
                    end
                    CMD_CERASE:
                    begin
                        op_next = CMD_CERASE;
                        list[n[RES_IDX_W-1:0]] = tx_res(FL_WREN, 1'b1, 1'b0);
                        n = n + 1'b1;
                        list[n[RES_IDX_W-1:0]] = tx_res(FL_CE, 1'b1, 1'b0);
                        n = n + 1'b1;
                        do_poll = 1'b1;
                    end
                    CMD_EPROG:
                    begin
                        if (length == '0)
                        begin
                            n = n + 1'b1;
                            finished = 1'b1;
                        end
                        else
                        begin
                            // Start erasing from the sector that holds the first byte.
                            op_next   = CMD_EPROG;
                            rem_next  = length;
                            end_next  = {1'b0, address} + {1'b0, length};
                            addr_next = address & SEC_MASK;
                            sec_addr  = address & SEC_MASK;
                            do_sector = 1'b1;
                        end
                    end
                    CMD_STATUS:
                    begin
                        list[n[RES_IDX_W-1:0]] = tx_res(FL_RDSR, 1'b0, 1'b0);
                        n = n + 1'b1;
                        list[n[RES_IDX_W-1:0]] = tx_res(FL_DUMMY, 1'b1, 1'b1);
                        n = n + 1'b1;
                        op_next    = CMD_STATUS;
                        phase_next = PH_STAT;
                    end
                    CMD_ID:
                    begin
                        list[n[RES_IDX_W-1:0]] = tx_res(FL_RDID, 1'b0, 1'b0);
                        n = n + 1'b1;
                        list[n[RES_IDX_W-1:0]] = tx_res(FL_DUMMY, 1'b0, 1'b1);
                        n = n + 1'b1;
                        rem_next   = ADDR_W'(3);
                        op_next    = CMD_ID;
                        phase_next = PH_ID;
                    end
                    CMD_WAKE:
                    begin
                        list[n[RES_IDX_W-1:0]] = tx_res(FL_RES, 1'b0, 1'b0);
                        n = n + 1'b1;
                        list[n[RES_IDX_W-1:0]] = tx_res(FL_DUMMY, 1'b0, 1'b0);
                        n = n + 1'b1;
                        list[n[RES_IDX_W-1:0]] = tx_res(FL_DUMMY, 1'b0, 1'b0);
                        n = n + 1'b1;
                        list[n[RES_IDX_W-1:0]] = tx_res(FL_DUMMY, 1'b1, 1'b0);
                        n = n + 1'b1;
                        finished = 1'b1;
                    end
                    default:
                    begin
                        reject = 1'b1;
                    end
                endcase
            end
            PH_READ, PH_ID:
            begin
                if (command != CMD_REPLY)
                begin
                    reject = 1'b1;
                end
                else
                begin
                    list[n[RES_IDX_W-1:0]] = host_res(data_byte);
                    n = n + 1'b1;
                    rem_next = rem_dec;
                    if (rem_dec != '0)
                    begin
                        list[n[RES_IDX_W-1:0]] = tx_res(FL_DUMMY,
                                                        rem_dec == ADDR_W'(1), 1'b1);
                        n = n + 1'b1;
                    end
                    else
                    begin
                        finished = 1'b1;
                    end
                end
            end
            PH_STAT:
            begin
                if (command != CMD_REPLY)
                begin
                    reject = 1'b1;
                end
                else
                begin
                    list[n[RES_IDX_W-1:0]] = host_res(data_byte);
                    n = n + 1'b1;
                    finished = 1'b1;
                end
            end
            PH_PROG:
            begin
                if (command != CMD_DATA)
                begin
                    reject = 1'b1;
                end
                else
                begin
                    list[n[RES_IDX_W-1:0]] = tx_res(data_byte, pbl_reg <= PBL_W'(1), 1'b0);
                    n = n + 1'b1;
                    pbl_next  = (pbl_reg != '0) ? pbl_reg - PBL_W'(1) : pbl_reg;
                    rem_next  = rem_dec;
                    addr_next = addr_reg + ADDR_W'(1);
                    do_poll   = (pbl_next == '0);
                end
            end
            PH_POLL:
            begin
                if (command != CMD_REPLY)
                begin
                    reject = 1'b1;
                end
                else if ((data_byte & SR_BUSY) != '0)
                begin
                    do_poll = 1'b1;
                end
                else
                begin
                    list[n[RES_IDX_W-1:0]] = tx_res(FL_WRDI, 1'b1, 1'b0);
                    n = n + 1'b1;
                    if (op_reg == CMD_PROG)
                    begin
                        if (rem_reg != '0)
                        begin
                            do_page = 1'b1;
                        end
                        else
                        begin
                            finished = 1'b1;
                        end
                    end
                    else if (op_reg == CMD_EPROG)
                    begin
                        if (nxt < end_reg)
                        begin
                            // Past the top of the array both pointers wrap together.
                            if (nxt[ADDR_W])
                            begin
                                end_next = {1'b0, end_reg[ADDR_W-1:0]};
                            end
                            addr_next = nxt[ADDR_W-1:0];
                            sec_addr  = nxt[ADDR_W-1:0];
                            do_sector = 1'b1;
                        end
                        else
                        begin
                            op_next   = CMD_PROG;
                            addr_next = diff[ADDR_W-1:0];
                            do_page   = 1'b1;
                        end
                    end
                    else
                    begin
                        finished = 1'b1;
                    end
                end
            end
            default:
            begin
                reject = 1'b1;
            end
        endcase

        if (do_sector)
        begin
            list[n[RES_IDX_W-1:0]] = tx_res(FL_WREN, 1'b1, 1'b0);
            n = n + 1'b1;
            list[n[RES_IDX_W-1:0]] = tx_res(FL_SE, 1'b0, 1'b0);
            n = n + 1'b1;
            list[n[RES_IDX_W-1:0]] = tx_res(sec_addr[23:16], 1'b0, 1'b0);
            n = n + 1'b1;
            list[n[RES_IDX_W-1:0]] = tx_res(sec_addr[15:8], 1'b0, 1'b0);
            n = n + 1'b1;
            list[n[RES_IDX_W-1:0]] = tx_res(sec_addr[7:0], 1'b1, 1'b0);
            n = n + 1'b1;
            do_poll = 1'b1;
        end

        if (do_page)
        begin
            // The first page may be partial: stop at the next page boundary.
            off  = addr_next[PG_W-1:0];
            room = PBL_W'(PAGE_BYTES) - {1'b0, off};
            pbl_next = (rem_next < ADDR_W'(room)) ? rem_next[PBL_W-1:0] : room;
            list[n[RES_IDX_W-1:0]] = tx_res(FL_WREN, 1'b1, 1'b0);
            n = n + 1'b1;
            list[n[RES_IDX_W-1:0]] = tx_res(FL_PP, 1'b0, 1'b0);
            n = n + 1'b1;
            list[n[RES_IDX_W-1:0]] = tx_res(addr_next[23:16], 1'b0, 1'b0);
            n = n + 1'b1;
            list[n[RES_IDX_W-1:0]] = tx_res(addr_next[15:8], 1'b0, 1'b0);
            n = n + 1'b1;
            list[n[RES_IDX_W-1:0]] = tx_res(addr_next[7:0], 1'b0, 1'b0);
            n = n + 1'b1;
            phase_next = PH_PROG;
        end

        if (do_poll)
        begin
            list[n[RES_IDX_W-1:0]] = tx_res(FL_RDSR, 1'b0, 1'b0);
            n = n + 1'b1;
            list[n[RES_IDX_W-1:0]] = tx_res(FL_DUMMY, 1'b1, 1'b1);
            n = n + 1'b1;
            phase_next = PH_POLL;
        end

        if (reject)
        begin
            // A rejected request leaves the state exactly as it was.
            phase_next = phase_reg;
            op_next    = op_reg;
            addr_next  = addr_reg;
            rem_next   = rem_reg;
            end_next   = end_reg;
            pbl_next   = pbl_reg;
            list       = '0;
            list[0].rejected = 1'b1;
            n = RES_CNT_W'(1);
        end

        nl = n - 1'b1;
        if (finished)
        begin
            phase_next = PH_IDLE;
            op_next    = OP_NONE;
            list[nl[RES_IDX_W-1:0]].op_done = 1'b1;
        end
        list[nl[RES_IDX_W-1:0]].last = 1'b1;
        count = n;
    end

endmodule

`default_nettype wire

// ===== sv/sfs_res_queue.sv =====
// Result queue of the SPI NOR flash sequencer: holds one request's results and
// hands them out one per cycle while out_ready is high. Uses sfs_pkg.
`default_nettype none

module sfs_res_queue
    import sfs_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    load,
    input  res_t      [MAX_RES-1:0]      list,
    input  wire logic [RES_CNT_W-1:0]    count,
    output logic                         can_load,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output res_t                         head
);

    res_t [MAX_RES-1:0]     q_reg;
    logic [RES_CNT_W-1:0]   cnt_reg;
    logic                   pop;

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    // A new list may go in once the last result of the old one leaves.
    assign can_load  = (cnt_reg == '0) || ((cnt_reg == RES_CNT_W'(1)) && out_ready);
    assign head      = q_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= count;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= list;
        end
        else if (pop)
        begin
            for (int i = 0; i < MAX_RES - 1; i++)
            begin
                q_reg[i] <= q_reg[i + 1];
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/spi_nor_flash_sequencer.sv =====
// Top level of the SPI NOR flash sequencer: request register, core and result queue.
// Depends on sfs_pkg, sfs_core and sfs_res_queue.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  input   | in_valid / in_ready  | command, address, length, data_byte
//  output  | out_valid / out_ready| mosi_valid, mosi_byte, frame_end, want_reply,
//          |                      | host_valid, host_byte, op_done, rejected, last
//
// Each request gives one to eight results; they leave the result queue one per cycle
// while out_ready is high.
// With the result queue empty, a taken request goes from the request register straight
// into the result queue, whose head is then the first result.
// A new request can be taken into the request register while the previous one's results are still draining.
// Reset returns the sequencer to idle with cleared pointers and counters.
// Stalls on the output back up into the request register and then into in_ready.
`default_nettype none

module spi_nor_flash_sequencer
    import sfs_pkg::*;
#(
    parameter int PAGE_BYTES   = 256,
    parameter int SECTOR_BYTES = 4096
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [3:0]        command,
    input  wire logic [ADDR_W-1:0] address,
    input  wire logic [ADDR_W-1:0] length,
    input  wire logic [7:0]        data_byte,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   mosi_valid,
    output logic [7:0]             mosi_byte,
    output logic                   frame_end,
    output logic                   want_reply,
    output logic                   host_valid,
    output logic [7:0]             host_byte,
    output logic                   op_done,
    output logic                   rejected,
    output logic                   last
);

    logic               in_valid_reg;
    logic [3:0]         command_reg;
    logic [ADDR_W-1:0]  address_reg;
    logic [ADDR_W-1:0]  length_reg;
    logic [7:0]         data_byte_reg;
    logic               can_load;
    logic               fire;
    res_t [MAX_RES-1:0] list;
    logic [RES_CNT_W-1:0] count;
    res_t               head;

    assign fire     = in_valid_reg && can_load;
    assign in_ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            command_reg   <= command;
            address_reg   <= address;
            length_reg    <= length;
            data_byte_reg <= data_byte;
        end
    end

    sfs_core #(
        .PAGE_BYTES   (PAGE_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .command   (command_reg),
        .address   (address_reg),
        .length    (length_reg),
        .data_byte (data_byte_reg),
        .list      (list),
        .count     (count)
    );

    sfs_res_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .list      (list),
        .count     (count),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign mosi_valid = head.mosi_valid;
    assign mosi_byte  = head.mosi_byte;
    assign frame_end  = head.frame_end;
    assign want_reply = head.want_reply;
    assign host_valid = head.host_valid;
    assign host_byte  = head.host_byte;
    assign op_done    = head.op_done;
    assign rejected   = head.rejected;
    assign last       = head.last;

endmodule

`default_nettype wire

// ===== sv/sfs_checker.sv =====
// Port-level checks for the SPI NOR flash sequencer, bound to its top level.
// Sees only the top level's ports; no package needed.
`default_nettype none

module sfs_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        mosi_valid,
    input wire logic [7:0]  mosi_byte,
    input wire logic        frame_end,
    input wire logic        want_reply,
    input wire logic        host_valid,
    input wire logic [7:0]  host_byte,
    input wire logic        op_done,
    input wire logic        rejected,
    input wire logic        last
);

    // A stalled result keeps its valid, both byte fields and its last, op_done and rejected flags.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mosi_byte) && $stable(host_byte)
            && $stable(last) && $stable(op_done) && $stable(rejected))
        else $error("result changed while stalled");

    // A rejection is a lone, empty result.
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> last && !mosi_valid && !host_valid && !op_done)
        else $error("rejection carries data or is not last");

    // Completion is always marked on the final result of a request.
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && op_done |-> last)
        else $error("op_done on a result that is not last");

    // Only dummy bytes ask for the flash's answer to be returned.
    a_want_reply: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && want_reply |-> mosi_valid && (mosi_byte == 8'hFF) && !host_valid)
        else $error("want_reply on a byte that is not a dummy transfer");

    // Empty byte fields read as zero.
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mosi_valid || (mosi_byte == 8'h00 && !frame_end))
            && (host_valid || host_byte == 8'h00))
        else $error("unused byte field is not zero");

endmodule

bind spi_nor_flash_sequencer sfs_checker u_sfs_checker (.*);

`default_nettype wire
